// ===== sv/ddo_pkg.sv =====
// ----------------------------------------------------------------------------
// ddo_pkg
// Shared types, constants and helpers of the differential drive odometry core.
// ----------------------------------------------------------------------------
package ddo_pkg;

    // Default parameter values
    localparam int COUNT_BITS_DEF   = 16;
    localparam int ANGLE_BITS_DEF   = 24;
    localparam int CORDIC_STEPS_DEF = 16;

    // Fixed field widths
    localparam int CFG_W   = 16;
    localparam int POS_W   = 32;
    localparam int HEAD_W  = 24;
    localparam int OUT_W   = 2 * POS_W + HEAD_W;

    // Shared multiplier operand and product widths
    localparam int MUL_W   = 34;
    localparam int PROD_W  = 2 * MUL_W;

    // CORDIC datapath width and accumulation width for saturation
    localparam int CORD_W  = 34;
    localparam int ACC_W   = 40;
    localparam int PROD_SH = 30;

    // Configuration register indexes
    localparam logic CFG_DIST_PER_COUNT  = 1'b0;
    localparam logic CFG_ANGLE_PER_COUNT = 1'b1;

    // Register reset values
    localparam logic [CFG_W-1:0] DIST_RESET  = 16'd1311;
    localparam logic [CFG_W-1:0] ANGLE_RESET = 16'd2225;

    // CORDIC gain inverse, Q2.30
    localparam logic signed [CORD_W-1:0] GAIN_INV = 34'sd652032875;

    // Arctangent table, 2^32 units per turn
    localparam int ATAN_N     = 24;
    localparam int ATAN_IDX_W = 5;
    localparam logic [31:0] ATAN_TAB [0:ATAN_N-1] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MHEAD,
        ST_MMAG,
        ST_CINIT,
        ST_CITER,
        ST_MX,
        ST_MY,
        ST_ACCY,
        ST_DONE
    } t_state;

    // Multiplier operand selection
    typedef enum logic [1:0] {
        MS_HEAD,
        MS_MAG,
        MS_X,
        MS_Y
    } t_mul_sel;

    // Sequencer to datapath controls
    typedef struct packed {
        logic     in_ready;
        t_mul_sel mul_sel;
        logic     mul_en;
        logic     head_upd;
        logic     cord_init;
        logic     cord_step;
        logic     x_upd;
        logic     y_upd;
        logic     out_load;
    } t_ctrl;

    // Clamp to the signed 32-bit range
    function automatic logic signed [POS_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = 40'sh007FFFFFFF;
        lo = -40'sh0080000000;
        if (v > hi) begin
            return 32'sh7FFFFFFF;
        end else if (v < lo) begin
            return 32'sh80000000;
        end
        return v[POS_W-1:0];
    endfunction

endpackage

// ===== sv/ddo_mul.sv =====
// ----------------------------------------------------------------------------
// ddo_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module ddo_mul (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic signed [ddo_pkg::MUL_W-1:0]     i_a,
    input  logic signed [ddo_pkg::MUL_W-1:0]     i_b,
    output logic signed [ddo_pkg::PROD_W-1:0]    o_prod
);

    logic signed [ddo_pkg::PROD_W-1:0] r_prod;

    // One product per enabled cycle
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= i_a * i_b;
        end
    end

    assign o_prod = r_prod;

endmodule

// ===== sv/ddo_cordic.sv =====
// ----------------------------------------------------------------------------
// ddo_cordic
// Iterative rotation-mode CORDIC: one micro-rotation per stepped cycle, sin
// and cos of a binary angle in Q2.30.
// ----------------------------------------------------------------------------
module ddo_cordic #(
    parameter int ANGLE_BITS   = ddo_pkg::ANGLE_BITS_DEF,
    parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_init,
    input  logic                               i_step,
    input  logic [ANGLE_BITS-1:0]              i_angle,
    output logic signed [ddo_pkg::CORD_W-1:0]  o_sin,
    output logic signed [ddo_pkg::CORD_W-1:0]  o_cos,
    output logic                               o_done
);

    localparam int ITER     = (CORDIC_STEPS < ddo_pkg::ATAN_N) ? CORDIC_STEPS
                                                                : ddo_pkg::ATAN_N;
    localparam int CNT_W    = $clog2(ITER);
    localparam int PHASE_SH = 32 - ANGLE_BITS;

    logic signed [ddo_pkg::CORD_W-1:0] r_cx, n_cx;
    logic signed [ddo_pkg::CORD_W-1:0] r_cy, n_cy;
    logic signed [ddo_pkg::CORD_W-1:0] r_z,  n_z;
    logic [CNT_W-1:0]                  r_cnt, n_cnt;

    logic [31:0]                       w_phase;
    logic [31:0]                       w_phase_r;
    logic                              w_reflect;
    logic signed [ddo_pkg::CORD_W-1:0] w_dx;
    logic signed [ddo_pkg::CORD_W-1:0] w_dy;
    logic signed [ddo_pkg::CORD_W-1:0] w_atan;

    // Start vector: back half turn is reflected with a negated start
    always_comb begin
        w_phase   = 32'(i_angle) << PHASE_SH;
        w_reflect = w_phase[31] ^ w_phase[30];
        w_phase_r = w_reflect ? (w_phase ^ 32'h80000000) : w_phase;
    end

    // Shared shift and add/sub step
    always_comb begin
        w_dx   = r_cy >>> r_cnt;
        w_dy   = r_cx >>> r_cnt;
        w_atan = ddo_pkg::CORD_W'(ddo_pkg::ATAN_TAB[ddo_pkg::ATAN_IDX_W'(r_cnt)]);
        n_cx   = r_cx;
        n_cy   = r_cy;
        n_z    = r_z;
        n_cnt  = r_cnt;
        if (i_init) begin
            n_cx  = w_reflect ? -ddo_pkg::GAIN_INV : ddo_pkg::GAIN_INV;
            n_cy  = '0;
            n_z   = ddo_pkg::CORD_W'($signed(w_phase_r));
            n_cnt = '0;
        end else if (i_step) begin
            if (!r_z[ddo_pkg::CORD_W-1]) begin
                n_cx = r_cx - w_dx;
                n_cy = r_cy + w_dy;
                n_z  = r_z - w_atan;
            end else begin
                n_cx = r_cx + w_dx;
                n_cy = r_cy - w_dy;
                n_z  = r_z + w_atan;
            end
            n_cnt = r_cnt + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_cx  <= n_cx;
        r_cy  <= n_cy;
        r_z   <= n_z;
        r_cnt <= n_cnt;
    end

    assign o_sin  = r_cy;
    assign o_cos  = r_cx;
    assign o_done = (r_cnt == CNT_W'(ITER - 1));

endmodule

// ===== sv/ddo_fsm.sv =====
// ----------------------------------------------------------------------------
// ddo_fsm
// Sequencer: steps one transaction through the shared multiplier and CORDIC.
// ----------------------------------------------------------------------------
module ddo_fsm (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_out_busy,
    input  logic            i_cord_done,
    output ddo_pkg::t_ctrl  o_ctrl
);

    ddo_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ddo_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and controls
    always_comb begin
        n_state          = r_state;
        o_ctrl           = '0;
        o_ctrl.mul_sel   = ddo_pkg::MS_HEAD;
        case (r_state)
            ddo_pkg::ST_IDLE: begin
                o_ctrl.in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = ddo_pkg::ST_MHEAD;
                end
            end
            ddo_pkg::ST_MHEAD: begin
                o_ctrl.mul_en  = 1'b1;
                o_ctrl.mul_sel = ddo_pkg::MS_HEAD;
                n_state        = ddo_pkg::ST_MMAG;
            end
            ddo_pkg::ST_MMAG: begin
                o_ctrl.head_upd = 1'b1;
                o_ctrl.mul_en   = 1'b1;
                o_ctrl.mul_sel  = ddo_pkg::MS_MAG;
                n_state         = ddo_pkg::ST_CINIT;
            end
            ddo_pkg::ST_CINIT: begin
                o_ctrl.cord_init = 1'b1;
                n_state          = ddo_pkg::ST_CITER;
            end
            ddo_pkg::ST_CITER: begin
                o_ctrl.cord_step = 1'b1;
                if (i_cord_done) begin
                    n_state = ddo_pkg::ST_MX;
                end
            end
            ddo_pkg::ST_MX: begin
                o_ctrl.mul_en  = 1'b1;
                o_ctrl.mul_sel = ddo_pkg::MS_X;
                n_state        = ddo_pkg::ST_MY;
            end
            ddo_pkg::ST_MY: begin
                o_ctrl.x_upd   = 1'b1;
                o_ctrl.mul_en  = 1'b1;
                o_ctrl.mul_sel = ddo_pkg::MS_Y;
                n_state        = ddo_pkg::ST_ACCY;
            end
            ddo_pkg::ST_ACCY: begin
                o_ctrl.y_upd = 1'b1;
                n_state      = ddo_pkg::ST_DONE;
            end
            ddo_pkg::ST_DONE: begin
                if (!i_out_busy) begin
                    o_ctrl.out_load = 1'b1;
                    n_state         = ddo_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ddo_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/differential_drive_odometry_core.sv =====
// ----------------------------------------------------------------------------
// differential_drive_odometry_core
// Dead-reckoning pose tracker for a two-wheel differential drive.
// ----------------------------------------------------------------------------
// Each input transaction carries the left and right encoder count changes of
// one sample period and yields one output transaction with the updated x, y
// and heading. Once the input is accepted, the heading and magnitude products
// pass through the single shared multiplier, the CORDIC loop does one
// micro-rotation per cycle (step count capped at 24), the x and y products
// pass through it, the two accumulators update and the output register loads
// once the previous result is taken. The input is not ready while a
// transaction is being worked on and becomes ready in the cycle the result
// appears, so no new transaction is taken before the last is through; a
// finished result waits in the output register while the next transaction
// is accepted. Configuration writes are expected only while the core is idle.
// ----------------------------------------------------------------------------
module differential_drive_odometry_core #(
    parameter int COUNT_BITS   = ddo_pkg::COUNT_BITS_DEF,
    parameter int ANGLE_BITS   = ddo_pkg::ANGLE_BITS_DEF,
    parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Input stream
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // left_count, right_count
    input  logic [((2*COUNT_BITS+7)/8)*8-1:0] i_s_tdata,
    // Output stream
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // x_position, y_position, heading
    output logic [ddo_pkg::OUT_W-1:0]     o_m_tdata,
    // Configuration write port
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [ddo_pkg::CFG_W-1:0]     i_cfg_wdata
);

    localparam int DW = COUNT_BITS + 1;

    ddo_pkg::t_ctrl w_ctrl;

    logic [ddo_pkg::CFG_W-1:0]          r_dpc;
    logic [ddo_pkg::CFG_W-1:0]          r_apc;
    logic signed [COUNT_BITS-1:0]       r_left;
    logic signed [COUNT_BITS-1:0]       r_right;
    logic [ANGLE_BITS-1:0]              r_head;
    logic signed [ddo_pkg::POS_W-1:0]   r_x;
    logic signed [ddo_pkg::POS_W-1:0]   r_y;
    logic signed [ddo_pkg::POS_W-1:0]   r_disp;
    logic                               r_ovalid;
    logic [ddo_pkg::OUT_W-1:0]          r_odata;

    logic                               w_accept;
    logic signed [DW-1:0]               w_delta;
    logic signed [DW-1:0]               w_sum;
    logic [DW-1:0]                      w_asum;
    logic [DW-1:0]                      w_al;
    logic [DW-1:0]                      w_ar;
    logic                               w_neg;
    logic signed [ddo_pkg::POS_W-1:0]   w_mag;
    logic signed [ddo_pkg::MUL_W-1:0]   w_mul_a;
    logic signed [ddo_pkg::MUL_W-1:0]   w_mul_b;
    logic signed [ddo_pkg::PROD_W-1:0]  w_prod;
    logic signed [ddo_pkg::ACC_W-1:0]   w_term;
    logic signed [ddo_pkg::CORD_W-1:0]  w_sin;
    logic signed [ddo_pkg::CORD_W-1:0]  w_cos;
    logic                               w_cord_done;

    assign w_accept   = i_s_tvalid & w_ctrl.in_ready;
    assign o_s_tready = w_ctrl.in_ready;

    // Sequencer
    ddo_fsm u_fsm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_tvalid),
        .i_out_busy  (r_ovalid & ~i_m_tready),
        .i_cord_done (w_cord_done),
        .o_ctrl      (w_ctrl)
    );

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dpc <= ddo_pkg::DIST_RESET;
            r_apc <= ddo_pkg::ANGLE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ddo_pkg::CFG_DIST_PER_COUNT:  r_dpc <= i_cfg_wdata;
                ddo_pkg::CFG_ANGLE_PER_COUNT: r_apc <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Input capture
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_left  <= i_s_tdata[COUNT_BITS-1:0];
            r_right <= i_s_tdata[2*COUNT_BITS-1:COUNT_BITS];
        end
    end

    // Count difference, magnitude of sum and direction sign
    always_comb begin
        w_delta = DW'(r_left) - DW'(r_right);
        w_sum   = DW'(r_left) + DW'(r_right);
        w_asum  = w_sum[DW-1] ? DW'(-w_sum) : DW'(w_sum);
        w_al    = r_left[COUNT_BITS-1]  ? DW'(-DW'(r_left))  : DW'(r_left);
        w_ar    = r_right[COUNT_BITS-1] ? DW'(-DW'(r_right)) : DW'(r_right);
        w_neg   = ((w_al > w_ar) == (r_left > r_right));
    end

    // Multiplier operand selection
    always_comb begin
        case (w_ctrl.mul_sel)
            ddo_pkg::MS_HEAD: begin
                w_mul_a = ddo_pkg::MUL_W'(w_delta);
                w_mul_b = ddo_pkg::MUL_W'(r_apc);
            end
            ddo_pkg::MS_MAG: begin
                w_mul_a = ddo_pkg::MUL_W'(w_asum);
                w_mul_b = ddo_pkg::MUL_W'(r_dpc);
            end
            ddo_pkg::MS_X: begin
                w_mul_a = ddo_pkg::MUL_W'(r_disp);
                w_mul_b = ddo_pkg::MUL_W'(w_sin);
            end
            ddo_pkg::MS_Y: begin
                w_mul_a = ddo_pkg::MUL_W'(r_disp);
                w_mul_b = ddo_pkg::MUL_W'(w_cos);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    ddo_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (w_ctrl.mul_en),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    ddo_cordic #(
        .ANGLE_BITS   (ANGLE_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_init  (w_ctrl.cord_init),
        .i_step  (w_ctrl.cord_step),
        .i_angle (r_head),
        .o_sin   (w_sin),
        .o_cos   (w_cos),
        .o_done  (w_cord_done)
    );

    // Halved magnitude, saturated to 2^31 - 1 (product is never negative)
    always_comb begin
        if (|w_prod[ddo_pkg::PROD_W-1:32]) begin
            w_mag = 32'sh7FFFFFFF;
        end else begin
            w_mag = ddo_pkg::POS_W'(w_prod[31:1]);
        end
    end

    // Product scaled back from Q2.30, floor rounding
    assign w_term = ddo_pkg::ACC_W'(w_prod >>> ddo_pkg::PROD_SH);

    // Pose state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_x    <= '0;
            r_y    <= '0;
        end else begin
            if (w_ctrl.head_upd) begin
                r_head <= r_head + w_prod[ANGLE_BITS-1:0];
            end
            if (w_ctrl.x_upd) begin
                r_x <= ddo_pkg::sat32(ddo_pkg::ACC_W'(r_x) + w_term);
            end
            if (w_ctrl.y_upd) begin
                r_y <= ddo_pkg::sat32(ddo_pkg::ACC_W'(r_y) + w_term);
            end
        end
    end

    // Signed displacement
    always_ff @(posedge i_clk) begin
        if (w_ctrl.cord_init) begin
            r_disp <= w_neg ? -w_mag : w_mag;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_ctrl.out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.out_load) begin
            r_odata <= {ddo_pkg::HEAD_W'(r_head), r_y, r_x};
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;

endmodule

// ===== verif/differential_drive_odometry_core_test.sv =====
// ----------------------------------------------------------------------------
// differential_drive_odometry_core_test
// Self-checking bench for the differential drive odometry core.
// ----------------------------------------------------------------------------
// Encoder count pairs go in on the input stream and the bench keeps its own
// pose tracker (heading, CORDIC sine and cosine, saturating x and y). Each
// accepted input transaction queues the expected pose, and each output
// transaction is compared field by field against the oldest queued pose.
// A short directed table runs first at the reset register values, then
// random count pairs run under several register settings, extremes included.
// The sender pauses in random bursts, the receiver stalls on a rotating
// pattern and twice holds off long enough to back the core up.
// ----------------------------------------------------------------------------
module differential_drive_odometry_core_test;

    localparam int CYCLE_LIMIT     = 3000;
    localparam int ITEMS_PER_PHASE = 72;
    localparam int SETTLE_CYCLES   = 40;
    localparam int LONG_HOLD       = 250;
    localparam int N_PHASES        = 6;
    localparam int N_ROWS          = 23;

    // Pose as carried on o_m_tdata: heading on top, x in the low bits
    typedef struct packed {
        logic [ddo_pkg::HEAD_W-1:0]       heading;
        logic signed [ddo_pkg::POS_W-1:0] y;
        logic signed [ddo_pkg::POS_W-1:0] x;
    } t_pose;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic               typed;
        t_pose              want;
    } t_count_row;

    // Arctangent steps, 2^32 units per turn
    localparam longint ATAN_STEP [0:15] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861
    };
    localparam longint CORDIC_K = 652032875;

    // Register settings for the random phases
    localparam logic [ddo_pkg::CFG_W-1:0] DIST_SET  [0:N_PHASES-1] =
        '{16'd65535, 16'd0, 16'd1, 16'd0, 16'd1311, 16'd40000};
    localparam logic [ddo_pkg::CFG_W-1:0] ANGLE_SET [0:N_PHASES-1] =
        '{16'd65535, 16'd0, 16'd1, 16'd0, 16'd2225, 16'd12};

    // Directed count pairs; a pose is typed in only where it is obvious
    localparam t_count_row DIR_ROWS [0:N_ROWS-1] = '{
        '{16'sd0,      16'sd0,      1'b1, '{24'd0,    32'sd0, 32'sd0}},
        '{16'sd1,      -16'sd1,     1'b1, '{24'd4450, 32'sd0, 32'sd0}},
        '{-16'sd1,     16'sd1,      1'b1, '{24'd0,    32'sd0, 32'sd0}},
        '{16'sd10,     16'sd10,     1'b0, '0},
        '{-16'sd10,    -16'sd10,    1'b0, '0},
        '{16'sd7,      16'sd0,      1'b0, '0},
        '{16'sd0,      -16'sd7,     1'b0, '0},
        '{16'sd32767,  16'sd32767,  1'b0, '0},
        '{-16'sd32768, -16'sd32768, 1'b0, '0},
        '{16'sd32767,  -16'sd32768, 1'b0, '0},
        '{-16'sd32768, 16'sd32767,  1'b0, '0},
        '{16'sd4000,   16'sd0,      1'b0, '0},
        '{16'sd0,      16'sd4000,   1'b0, '0},
        '{16'sd2000,   -16'sd2000,  1'b0, '0},
        '{16'sd300,    16'sd100,    1'b0, '0},
        '{16'sd100,    16'sd300,    1'b0, '0},
        '{-16'sd300,   -16'sd100,   1'b0, '0},
        '{-16'sd100,   -16'sd300,   1'b0, '0},
        '{-16'sd300,   16'sd100,    1'b0, '0},
        '{16'sd100,    -16'sd300,   1'b0, '0},
        '{16'sd0,      16'sd32767,  1'b0, '0},
        '{-16'sd32768, 16'sd0,      1'b0, '0},
        '{16'sh5555,   16'shAAAA,   1'b0, '0}
    };

    logic                        i_clk       = 1'b0;
    logic                        i_rst_n     = 1'b0;
    logic                        i_s_tvalid  = 1'b0;
    logic                        o_s_tready;
    logic [31:0]                 i_s_tdata   = '0;   // left_count, right_count
    logic                        o_m_tvalid;
    logic                        i_m_tready  = 1'b0;
    logic [ddo_pkg::OUT_W-1:0]   o_m_tdata;          // x_position, y_position, heading
    logic                        i_cfg_we    = 1'b0;
    logic                        i_cfg_index = ddo_pkg::CFG_DIST_PER_COUNT;
    logic [ddo_pkg::CFG_W-1:0]   i_cfg_wdata = '0;

    // Tracker state and its copy of the registers
    logic [ddo_pkg::CFG_W-1:0]        dist_cfg  = ddo_pkg::DIST_RESET;
    logic [ddo_pkg::CFG_W-1:0]        angle_cfg = ddo_pkg::ANGLE_RESET;
    logic [ddo_pkg::HEAD_W-1:0]       track_heading = '0;
    logic signed [ddo_pkg::POS_W-1:0] track_x = '0;
    logic signed [ddo_pkg::POS_W-1:0] track_y = '0;

    t_pose pose_q [$];
    t_pose seen_pose;
    t_pose due_pose;
    int    fails        = 0;
    int    poses_seen   = 0;
    int    burst_left   = 0;
    int    hold_left    = 0;
    int    next_hold_at = 60;
    int    stall_cycles = 0;
    logic [7:0] rx_cycle = '0;

    differential_drive_odometry_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #6 i_clk = ~i_clk;

    function automatic logic signed [ddo_pkg::POS_W-1:0] clamp32(input longint v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[ddo_pkg::POS_W-1:0];
    endfunction

    // Rotation-mode CORDIC; back half turn is folded with a negated start
    function automatic void heading_sin_cos(input logic [ddo_pkg::HEAD_W-1:0] hd,
                                            output longint s, output longint c);
        logic [31:0] phase;
        longint      cx;
        longint      cy;
        longint      z;
        longint      dx;
        longint      dy;
        phase = {hd, 8'h00};
        cx = CORDIC_K;
        cy = 0;
        if (phase[31:30] == 2'b01 || phase[31:30] == 2'b10) begin
            phase = phase - 32'h8000_0000;
            cx = -cx;
        end
        z = longint'($signed(phase));
        for (int i = 0; i < 16; i++) begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (z >= 0) begin
                cx = cx - dx;
                cy = cy + dy;
                z  = z - ATAN_STEP[i];
            end else begin
                cx = cx + dx;
                cy = cy - dy;
                z  = z + ATAN_STEP[i];
            end
        end
        s = cy;
        c = cx;
    endfunction

    // Advance the tracked pose by one count pair and return it
    function automatic t_pose advance_pose(input logic signed [15:0] l,
                                           input logic signed [15:0] r);
        longint lv;
        longint rv;
        longint dh;
        longint sum;
        longint mag;
        longint disp;
        longint sn;
        longint cs;
        lv  = l;
        rv  = r;
        dh  = (lv - rv) * longint'(angle_cfg);
        track_heading = track_heading + dh[ddo_pkg::HEAD_W-1:0];
        sum = lv + rv;
        if (sum < 0) begin
            sum = -sum;
        end
        mag = (longint'(dist_cfg) * sum) >>> 1;
        if (mag > 64'sd2147483647) begin
            mag = 64'sd2147483647;
        end
        // Negative travel when the larger wheel is also the leading one
        disp = (((lv < 0 ? -lv : lv) > (rv < 0 ? -rv : rv)) == (lv > rv)) ? -mag : mag;
        heading_sin_cos(track_heading, sn, cs);
        track_x = clamp32(longint'(track_x) + ((disp * sn) >>> 30));
        track_y = clamp32(longint'(track_y) + ((disp * cs) >>> 30));
        return '{track_heading, track_y, track_x};
    endfunction

    function automatic logic signed [15:0] random_count();
        int pick;
        int v;
        pick = $urandom_range(0, 19);
        if (pick < 10) begin
            v = int'($urandom_range(0, 511)) - 256;
        end else if (pick < 15) begin
            v = int'($urandom_range(0, 8191)) - 4096;
        end else if (pick < 18) begin
            v = int'($urandom_range(0, 65535)) - 32768;
        end else begin
            case ($urandom_range(0, 4))
                0: v = -32768;
                1: v = -1;
                2: v = 0;
                3: v = 1;
                default: v = 32767;
            endcase
        end
        return 16'(v);
    endfunction

    // Offer one count pair and wait for the input transaction
    task automatic send_counts(input logic signed [15:0] l, input logic signed [15:0] r,
                               input logic typed, input t_pose want);
        t_pose predicted;
        i_s_tdata  <= {r, l};
        i_s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!o_s_tready) begin
            @(posedge i_clk);
        end
        predicted = advance_pose(l, r);
        pose_q.push_back(typed ? want : predicted);
    endtask

    // Burst pacing: random burst lengths separated by random gaps
    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 12);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 8);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Let the core go idle before touching the registers
    task automatic end_phase();
        i_s_tvalid <= 1'b0;
        while (pose_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [ddo_pkg::CFG_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        if (idx == ddo_pkg::CFG_DIST_PER_COUNT) begin
            dist_cfg = val;
        end else begin
            angle_cfg = val;
        end
    endtask

    task automatic report_field(input string field, input longint want, input longint got);
        fails++;
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
    endtask

    // Compare each output transaction with the oldest expected pose
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            seen_pose = o_m_tdata;
            if (pose_q.size() == 0) begin
                fails++;
                $display("%0t: unexpected pose: expected none, got x %0d y %0d heading %0d",
                         $time, seen_pose.x, seen_pose.y, seen_pose.heading);
            end else begin
                due_pose = pose_q.pop_front();
                poses_seen++;
                if (seen_pose.x !== due_pose.x) begin
                    report_field("x_position", due_pose.x, seen_pose.x);
                end
                if (seen_pose.y !== due_pose.y) begin
                    report_field("y_position", due_pose.y, seen_pose.y);
                end
                if (seen_pose.heading !== due_pose.heading) begin
                    report_field("heading", due_pose.heading, seen_pose.heading);
                end
            end
        end
    end

    // Receiver: rotating stall pattern plus occasional long hold-offs
    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 8'd1;
        if (hold_left != 0) begin
            hold_left  <= hold_left - 1;
            i_m_tready <= 1'b0;
        end else if (poses_seen >= next_hold_at) begin
            hold_left    <= LONG_HOLD;
            next_hold_at <= next_hold_at + 240;
            i_m_tready   <= 1'b0;
        end else begin
            case (rx_cycle[7:6])
                2'd0: i_m_tready <= 1'b1;
                2'd1: i_m_tready <= 1'($urandom_range(0, 1));
                2'd2: i_m_tready <= (rx_cycle[1:0] == 2'd0);
                default: i_m_tready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == CYCLE_LIMIT) begin
            $display("** differential_drive_odometry_core: FAILED **");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        logic signed [15:0] l;
        logic signed [15:0] r;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows at the reset register values
        for (int k = 0; k < N_ROWS; k++) begin
            send_counts(DIR_ROWS[k].left, DIR_ROWS[k].right, DIR_ROWS[k].typed,
                        DIR_ROWS[k].want);
            pace_sender();
        end
        end_phase();

        // Random count pairs under each register setting
        for (int p = 0; p < N_PHASES; p++) begin
            write_reg(ddo_pkg::CFG_DIST_PER_COUNT,
                      (p == 3) ? 16'($urandom) : DIST_SET[p]);
            write_reg(ddo_pkg::CFG_ANGLE_PER_COUNT,
                      (p == 3) ? 16'($urandom) : ANGLE_SET[p]);
            i_cfg_we <= 1'b0;
            repeat (ITEMS_PER_PHASE) begin
                l = random_count();
                case ($urandom_range(0, 9))
                    0: r = l;
                    1: r = -l;
                    default: r = random_count();
                endcase
                send_counts(l, r, 1'b0, '0);
                pace_sender();
            end
            end_phase();
        end

        if (fails == 0) begin
            $display("** differential_drive_odometry_core: PASSED **");
        end else begin
            $display("** differential_drive_odometry_core: FAILED **");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/ddo_pkg.sv
sv/ddo_mul.sv
sv/ddo_cordic.sv
sv/ddo_fsm.sv
sv/differential_drive_odometry_core.sv
verif/differential_drive_odometry_core_test.sv
